@@ src/satag_pkg.sv @@
// Shared types and constants for the set-associative LRU tag store.
`default_nettype none
package satag_pkg;

   localparam int ADDR_W    = 32;
   localparam int LEN_W     = 8;
   localparam int WAY_OUT_W = 3;

   // Per-way status word; readable is implied by valid and is not stored.
   localparam int ST_W        = 3;
   localparam int ST_VALID    = 0;
   localparam int ST_WRITABLE = 1;
   localparam int ST_DIRTY    = 2;

   typedef struct packed {
      logic              mode;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic                 evicted_valid;
      logic                 line_dirty;
      logic                 line_writable;
   } rsp_type;

endpackage
`default_nettype wire

@@ src/satag_set_mem.sv @@
// One-port-write, one-port-read set memory with a registered read.
`default_nettype none
module satag_set_mem #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Hold the last read word until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ src/satag_update.sv @@
// Tag match, LRU reorder and status update for one set row.
`default_nettype none
module satag_update #(
   parameter int WAYS  = 8,
   parameter int TAG_W = 18,
   parameter int WAY_W = 3,
   parameter int ROW_W = WAYS * (TAG_W + satag_pkg::ST_W + WAY_W)
) (
   input  wire logic [ROW_W-1:0] row_in,
   input  wire logic [TAG_W-1:0] tag,
   input  wire logic             is_write,
   input  wire logic             full_block,
   output logic      [ROW_W-1:0] row_out,
   output satag_pkg::rsp_type    rsp
);

   localparam int ST_W     = satag_pkg::ST_W;
   localparam int ST_BASE  = WAYS * TAG_W;
   localparam int ORD_BASE = ST_BASE + WAYS * ST_W;

   logic [TAG_W-1:0] tags  [WAYS];
   logic [ST_W-1:0]  stat  [WAYS];
   logic [WAY_W-1:0] ord   [WAYS];
   logic [TAG_W-1:0] tags_n[WAYS];
   logic [ST_W-1:0]  stat_n[WAYS];
   logic [WAY_W-1:0] ord_n [WAYS];
   logic [WAYS-1:0]  match;
   logic             hit;
   logic [WAY_W-1:0] hit_way;
   logic [WAY_W-1:0] way;
   logic [WAY_W-1:0] pos;
   logic [ST_W-1:0]  st_old;
   logic [ST_W-1:0]  st_new;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         tags[w]  = row_in[w*TAG_W +: TAG_W];
         stat[w]  = row_in[ST_BASE + w*ST_W +: ST_W];
         ord[w]   = row_in[ORD_BASE + w*WAY_W +: WAY_W];
         match[w] = stat[w][satag_pkg::ST_VALID] && (tags[w] == tag);
      end
   end

   // At most one valid way carries a given tag, so a plain encode suffices.
   always_comb begin
      hit_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (match[w]) begin
            hit_way = WAY_W'(w);
         end
      end
   end

   assign hit = |match;
   assign way = hit ? hit_way : ord[WAYS-1];

   always_comb begin
      pos = '0;
      for (int p = 0; p < WAYS; p++) begin
         if (ord[p] == way) begin
            pos = WAY_W'(p);
         end
      end
   end

   // Move the way to the front, shift everything ahead of its old slot back.
   always_comb begin
      ord_n[0] = way;
      for (int p = 1; p < WAYS; p++) begin
         ord_n[p] = (WAY_W'(p) <= pos) ? ord[p-1] : ord[p];
      end
   end

   assign st_old = stat[way];

   always_comb begin
      st_new = st_old;
      if (hit) begin
         if (is_write) begin
            st_new[satag_pkg::ST_DIRTY] = 1'b1;
         end else if (full_block) begin
            st_new[satag_pkg::ST_WRITABLE] = 1'b0;
         end
      end else begin
         st_new[satag_pkg::ST_VALID]    = 1'b1;
         st_new[satag_pkg::ST_DIRTY]    = is_write;
         st_new[satag_pkg::ST_WRITABLE] = !is_write && !full_block;
      end
   end

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         tags_n[w] = (!hit && (WAY_W'(w) == way)) ? tag : tags[w];
         stat_n[w] = (WAY_W'(w) == way) ? st_new : stat[w];
      end
   end

   always_comb begin
      row_out = '0;
      for (int w = 0; w < WAYS; w++) begin
         row_out[w*TAG_W +: TAG_W]              = tags_n[w];
         row_out[ST_BASE + w*ST_W +: ST_W]      = stat_n[w];
         row_out[ORD_BASE + w*WAY_W +: WAY_W]   = ord_n[w];
      end
   end

   always_comb begin
      rsp.hit           = hit;
      rsp.way           = satag_pkg::WAY_OUT_W'(way);
      rsp.evicted_valid = !hit && st_old[satag_pkg::ST_VALID];
      rsp.line_dirty    = st_new[satag_pkg::ST_DIRTY];
      rsp.line_writable = st_new[satag_pkg::ST_WRITABLE];
   end

endmodule
`default_nettype wire

@@ src/set_assoc_lru_tag_store_core.sv @@
// A beat accepted while idle is read from the set memory into its read register,
// then updated, written back and loaded into the result register once that register
// is free; no new beat is taken until this read-modify-write of the set row is done.
// The result register frees the input side while a result beat waits to be taken.
// Reset: synchronous; afterwards a clearing pass writes every set row (all ways invalid,
// identity LRU order) while req_stall is held high.
`default_nettype none
module set_assoc_lru_tag_store_core #(
   parameter int SETS        = 256,
   parameter int WAYS        = 8,
   parameter int BLOCK_BYTES = 64,
   parameter int ADDR_BITS   = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire satag_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output satag_pkg::rsp_type      rsp_data
);

   localparam int AW        = satag_pkg::ADDR_W;
   localparam int ST_W      = satag_pkg::ST_W;
   localparam int SET_SHIFT = $clog2(BLOCK_BYTES + 1) - 1;
   localparam int TAG_SHIFT = SET_SHIFT + $clog2(SETS + 1) - 1;
   localparam int EFF_W     = (ADDR_BITS < AW) ? ADDR_BITS : AW;
   localparam int TAG_W     = (EFF_W > TAG_SHIFT) ? (EFF_W - TAG_SHIFT) : 1;
   localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ORD_BASE  = WAYS * (TAG_W + ST_W);
   localparam int ROW_W     = WAYS * (TAG_W + ST_W + WAY_W);
   localparam logic [AW-1:0]    ADDR_MASK = (ADDR_BITS >= AW) ? '1
                                          : ((AW'(1) << ADDR_BITS) - AW'(1));
   localparam logic [SET_W-1:0] SET_MASK  = SET_W'(SETS - 1);
   localparam logic [SET_W-1:0] SET_LAST  = SET_W'(SETS - 1);
   localparam logic [15:0]      BLOCK_LEN = 16'(BLOCK_BYTES);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type          state_ff;
   logic [SET_W-1:0]   clr_ff;
   logic [SET_W-1:0]   set_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic               write_ff;
   logic               full_ff;
   logic               rsp_valid_ff;
   satag_pkg::rsp_type rsp_ff;

   logic [AW-1:0]      addr_m;
   logic [SET_W-1:0]   set_in;
   logic [TAG_W-1:0]   tag_in;
   logic               full_in;
   logic               req_take;
   logic               rsp_free;
   logic               load_rsp;
   logic               mem_we;
   logic               mem_re;
   logic [SET_W-1:0]   mem_waddr;
   logic [ROW_W-1:0]   mem_wdata;
   logic [ROW_W-1:0]   mem_rdata;
   logic [ROW_W-1:0]   clear_row;
   logic [ROW_W-1:0]   upd_row;
   satag_pkg::rsp_type upd_rsp;

   assign addr_m  = req_data.address & ADDR_MASK;
   assign set_in  = SET_W'(addr_m >> SET_SHIFT) & SET_MASK;
   assign tag_in  = TAG_W'(addr_m >> TAG_SHIFT);
   assign full_in = ({5'd0, req_data.length, 3'd0} == BLOCK_LEN);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = (state_ff == ST_LOOKUP) && rsp_free;

   // Cleared row: all ways invalid, way j at recency position j.
   always_comb begin
      clear_row = '0;
      for (int p = 0; p < WAYS; p++) begin
         clear_row[ORD_BASE + p*WAY_W +: WAY_W] = WAY_W'(p);
      end
   end

   assign mem_re    = req_take;
   assign mem_we    = (state_ff == ST_CLEAR) || load_rsp;
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_ff : set_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? clear_row : upd_row;

   satag_set_mem #(
      .DEPTH  (SETS),
      .WIDTH  (ROW_W),
      .ADDR_W (SET_W)
   ) u_set_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (set_in),
      .rdata (mem_rdata)
   );

   satag_update #(
      .WAYS  (WAYS),
      .TAG_W (TAG_W),
      .WAY_W (WAY_W),
      .ROW_W (ROW_W)
   ) u_update (
      .row_in     (mem_rdata),
      .tag        (tag_ff),
      .is_write   (write_ff),
      .full_block (full_ff),
      .row_out    (upd_row),
      .rsp        (upd_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + SET_W'(1);
               if (clr_ff == SET_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_take) begin
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               // hold until the result register can take the beat
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_take) begin
         set_ff   <= set_in;
         tag_ff   <= tag_in;
         write_ff <= req_data.mode;
         full_ff  <= full_in;
      end
      if (load_rsp) begin
         rsp_ff <= upd_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_after_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOKUP))
      else $error("result beat appeared without a lookup");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("set memory read and write in the same cycle");

   a_blocked_lookup_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && rsp_valid_ff && rsp_stall) |=> state_ff == ST_LOOKUP)
      else $error("lookup left while result register was full");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.hit) |-> !rsp_ff.evicted_valid)
      else $error("hit reported an eviction");

   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (req_stall && !rsp_valid_ff))
      else $error("traffic during clearing pass");

endmodule
`default_nettype wire

@@ sim/tb_set_assoc_lru_tag_store_core.sv @@
// Self-checking testbench for the set-associative LRU tag store core.
module tb_set_assoc_lru_tag_store_core;

   localparam int N_SETS      = 256;
   localparam int N_WAYS      = 8;
   localparam int LINE_BYTES  = 64;
   localparam int OFFSET_W    = $clog2(LINE_BYTES);
   localparam int INDEX_W     = $clog2(N_SETS);
   localparam int TAG_W       = satag_pkg::ADDR_W - OFFSET_W - INDEX_W;
   localparam int RANDOM_BEATS = 1450;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_CYCLES = 10;

   localparam logic ACC_READ  = 1'b0;
   localparam logic ACC_WRITE = 1'b1;

   typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_ALTERNATE, STALL_HEAVY} stall_kind_type;

   typedef struct packed {
      satag_pkg::req_type beat;
      logic               wait_idle;
   } queued_access_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   satag_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   satag_pkg::rsp_type rsp_data;

   // predicted tag store contents
   logic [TAG_W-1:0]                tag_mem       [N_SETS][N_WAYS];
   bit                              line_valid    [N_SETS][N_WAYS];
   bit                              line_writable [N_SETS][N_WAYS];
   bit                              line_dirty    [N_SETS][N_WAYS];
   logic [satag_pkg::WAY_OUT_W-1:0] lru_order     [N_SETS][N_WAYS];

   queued_access_type  queued_accesses[$];
   satag_pkg::rsp_type expected_lookups[$];
   int unsigned        mismatch_count = 0;

   int unsigned    burst_left = 1;
   int unsigned    gap_left = 0;
   stall_kind_type stall_kind = STALL_NONE;
   int unsigned    stall_left = 0;

   set_assoc_lru_tag_store_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [satag_pkg::ADDR_W-1:0] line_addr(
         input logic [TAG_W-1:0] tag,
         input logic [INDEX_W-1:0] set_idx,
         input logic [OFFSET_W-1:0] offset);
      return {tag, set_idx, offset};
   endfunction

   function automatic void add_access(input logic mode,
                                      input logic [satag_pkg::ADDR_W-1:0] address,
                                      input logic [satag_pkg::LEN_W-1:0] length,
                                      input logic wait_idle);
      queued_access_type item;
      item.beat.mode    = mode;
      item.beat.address = address;
      item.beat.length  = length;
      item.wait_idle    = wait_idle;
      queued_accesses.insert(queued_accesses.size(), item);
   endfunction

   // Look up one access, update tags, status and LRU order, return the result beat.
   function automatic satag_pkg::rsp_type lookup_tag_store(input satag_pkg::req_type acc);
      logic [INDEX_W-1:0]              set_idx;
      logic [TAG_W-1:0]                tag;
      logic [satag_pkg::WAY_OUT_W-1:0] way;
      logic                            full_block;
      int                              hit_pos;
      satag_pkg::rsp_type              res;
      set_idx    = acc.address[OFFSET_W +: INDEX_W];
      tag        = acc.address[satag_pkg::ADDR_W-1 -: TAG_W];
      full_block = (int'(acc.length) * 8) == LINE_BYTES;
      hit_pos    = -1;
      res        = '0;
      for (int p = 0; p < N_WAYS; p++) begin
         if (hit_pos < 0 && line_valid[set_idx][lru_order[set_idx][p]] &&
             tag_mem[set_idx][lru_order[set_idx][p]] == tag)
            hit_pos = p;
      end
      if (hit_pos >= 0) begin
         way     = lru_order[set_idx][hit_pos];
         res.hit = 1'b1;
         if (acc.mode == ACC_WRITE)
            line_dirty[set_idx][way] = 1'b1;
         else if (full_block)
            line_writable[set_idx][way] = 1'b0;
      end else begin
         hit_pos = N_WAYS - 1;
         way     = lru_order[set_idx][hit_pos];
         res.evicted_valid = line_valid[set_idx][way];
         tag_mem[set_idx][way]       = tag;
         line_valid[set_idx][way]    = 1'b1;
         line_dirty[set_idx][way]    = (acc.mode == ACC_WRITE);
         line_writable[set_idx][way] = (acc.mode == ACC_READ) && !full_block;
      end
      // promote to most recent
      for (int p = hit_pos; p > 0; p--)
         lru_order[set_idx][p] = lru_order[set_idx][p-1];
      lru_order[set_idx][0] = way;
      res.way           = way;
      res.line_dirty    = line_dirty[set_idx][way];
      res.line_writable = line_writable[set_idx][way];
      return res;
   endfunction

   // Driver: offer beats in bursts, hold a stalled beat, predict on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_lookups.insert(expected_lookups.size(), lookup_tag_store(req_data));
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (queued_accesses.size() == 0 ||
                         (queued_accesses[0].wait_idle && expected_lookups.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= queued_accesses[0].beat;
               queued_accesses.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // Receiver stall pattern: switch at random between four stall styles.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_kind <= stall_kind_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(8, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_kind)
         STALL_NONE:      rsp_stall <= 1'b0;
         STALL_RANDOM:    rsp_stall <= 1'($urandom_range(0, 1));
         STALL_ALTERNATE: rsp_stall <= ~rsp_stall;
         default:         rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Monitor: compare each accepted result beat with the oldest prediction.
   always @(posedge clock) begin : result_monitor
      satag_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: hit %0d way %0d evict %0d dirty %0d wr %0d",
                        rsp_data.hit, rsp_data.way, rsp_data.evicted_valid,
                        rsp_data.line_dirty, rsp_data.line_writable);
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_data.hit !== want.hit || rsp_data.way !== want.way ||
                rsp_data.evicted_valid !== want.evicted_valid ||
                rsp_data.line_dirty !== want.line_dirty ||
                rsp_data.line_writable !== want.line_writable) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected hit %0d way %0d evict %0d dirty %0d wr %0d,",
                            " got hit %0d way %0d evict %0d dirty %0d wr %0d"},
                           want.hit, want.way, want.evicted_valid, want.line_dirty,
                           want.line_writable, rsp_data.hit, rsp_data.way,
                           rsp_data.evicted_valid, rsp_data.line_dirty,
                           rsp_data.line_writable);
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned n_cycles;
      n_cycles = 0;
      while (n_cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         n_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      logic [INDEX_W-1:0]               hot_sets [4];
      logic [TAG_W-1:0]                 tag;
      logic [INDEX_W-1:0]               set_idx;
      logic [satag_pkg::ADDR_W-1:0]     address;
      logic [satag_pkg::LEN_W-1:0]      length;
      hot_sets = '{8'h00, 8'h03, 8'hFF, 8'h80};
      for (int s = 0; s < N_SETS; s++) begin
         for (int w = 0; w < N_WAYS; w++) begin
            tag_mem[s][w]       = TAG_W'(w);
            line_valid[s][w]    = 1'b0;
            line_writable[s][w] = 1'b0;
            line_dirty[s][w]    = 1'b0;
            lru_order[s][w]     = satag_pkg::WAY_OUT_W'(w);
         end
      end

      // read miss, full-block read hit, write hit on a read-only line
      add_access(ACC_READ,  32'h0000_0000, 8'd0,   1'b0);
      add_access(ACC_READ,  32'h0000_003F, 8'd8,   1'b0);
      add_access(ACC_WRITE, 32'h0000_0020, 8'd255, 1'b0);
      // all-ones address: write miss, then full-block read hit
      add_access(ACC_WRITE, 32'hFFFF_FFFF, 8'd255, 1'b0);
      add_access(ACC_READ,  32'hFFFF_FFC0, 8'd8,   1'b0);
      // full-block read miss leaves the line read-only, then write hit
      add_access(ACC_READ,  line_addr(18'd1, 8'd0, 6'd0), 8'd8, 1'b0);
      add_access(ACC_WRITE, line_addr(18'd1, 8'd0, 6'd5), 8'd7, 1'b0);
      // fill one set past its ways so the last fill evicts a valid line
      for (int t = 0; t < N_WAYS + 1; t++)
         add_access(t[0] ? ACC_WRITE : ACC_READ,
                    line_addr(TAG_W'(18'h100 + t), 8'd3, OFFSET_W'(t)), 8'd9, 1'b0);
      // touch a line so the victim order shifts, then miss twice
      add_access(ACC_READ,  line_addr(18'h101, 8'd3, 6'd0), 8'd8, 1'b0);
      add_access(ACC_WRITE, line_addr(18'h100, 8'd3, 6'd0), 8'd0, 1'b1);
      add_access(ACC_READ,  line_addr(18'h102, 8'd3, 6'd0), 8'd1, 1'b0);
      add_access(ACC_READ,  line_addr(18'h3FFFF, 8'hFF, 6'h3F), 8'd16, 1'b0);

      // random part: mostly a small pool of sets and tags so hits and evictions mix
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if ($urandom_range(0, 4) != 0) begin
            tag = TAG_W'($urandom_range(0, 5));
            if ($urandom_range(0, 1) != 0)
               tag = ~tag;
            set_idx = hot_sets[$urandom_range(0, 3)];
            address = line_addr(tag, set_idx, OFFSET_W'($urandom_range(0, LINE_BYTES - 1)));
         end else begin
            address = $urandom;
         end
         length = ($urandom_range(0, 3) == 0) ? 8'd8
                                               : satag_pkg::LEN_W'($urandom_range(0, 255));
         add_access(1'($urandom_range(0, 1)), address, length, (i % 300) == 299);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (queued_accesses.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_lookups.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
